/* design/olf_pkg.sv */
// Shared types and constants for the occupancy light fader.
package olf_pkg;

  // Widths of the configuration registers, the register index and the item operation.
  localparam int unsigned CfgTimeW = 24;
  localparam int unsigned StepW    = 13;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OpW      = 2;

  // Reset values of the configuration registers.
  localparam logic [CfgTimeW-1:0] RstSwitchOn    = 24'd30000;
  localparam logic [CfgTimeW-1:0] RstSwitchBlock = 24'd10000;
  localparam logic [CfgTimeW-1:0] RstMotionOn    = 24'd60000;
  localparam logic [StepW-1:0]    RstFadeStep    = 13'd32;

  // Item operations.
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_MOTION = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWITCH_ON    = 3'd0,
    CFG_SWITCH_BLOCK = 3'd1,
    CFG_MOTION_ON    = 3'd2,
    CFG_FADE_STEP    = 3'd3,
    CFG_INVERT       = 3'd4
  } cfg_idx_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [CfgTimeW-1:0] switch_on_time;
    logic [CfgTimeW-1:0] switch_block_time;
    logic [CfgTimeW-1:0] motion_on_time;
    logic [StepW-1:0]    fade_step;
    logic                invert_output;
  } cfg_t;

  // Single-bit result fields.
  typedef struct packed {
    logic output_held;
    logic held_level;
    logic duty_written;
    logic light_target_on;
  } res_flags_t;

endpackage

/* design/olf_cfg_regs.sv */
// Configuration register file of the occupancy light fader.
module olf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [olf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [olf_pkg::CfgDataW-1:0] cfg_data_i,
  output olf_pkg::cfg_t                cfg_o
);
  import olf_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SWITCH_ON:    cfg_d.switch_on_time    = cfg_data_i[CfgTimeW-1:0];
        CFG_SWITCH_BLOCK: cfg_d.switch_block_time = cfg_data_i[CfgTimeW-1:0];
        CFG_MOTION_ON:    cfg_d.motion_on_time    = cfg_data_i[CfgTimeW-1:0];
        CFG_FADE_STEP:    cfg_d.fade_step         = cfg_data_i[StepW-1:0];
        CFG_INVERT:       cfg_d.invert_output     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_on_time    <= RstSwitchOn;
      cfg_q.switch_block_time <= RstSwitchBlock;
      cfg_q.motion_on_time    <= RstMotionOn;
      cfg_q.fade_step         <= RstFadeStep;
      cfg_q.invert_output     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/olf_core.sv */
// Light state, countdowns, fade step and output encoding of the fader.
module olf_core #(
  parameter int unsigned DUTY_BITS = 13,
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [olf_pkg::OpW-1:0]  op_i,
  input  logic                     motion_level_i,
  input  olf_pkg::cfg_t            cfg_i,
  output logic [DUTY_BITS-1:0]     duty_o,
  output olf_pkg::res_flags_t      flags_o
);
  import olf_pkg::*;

  localparam int unsigned TimeKeepW = (TIME_BITS < CfgTimeW) ? TIME_BITS : CfgTimeW;
  localparam int unsigned SumW      = ((DUTY_BITS > StepW) ? DUTY_BITS : StepW) + 1;
  localparam int unsigned DutyOutW  = (DUTY_BITS < StepW) ? DUTY_BITS : StepW;
  localparam logic [DUTY_BITS-1:0] LvlMax  = {DUTY_BITS{1'b1}};
  localparam logic [SumW-1:0]      LvlMaxX = SumW'(LvlMax);
  localparam logic [TIME_BITS-1:0] RstAutoOff = TIME_BITS'(RstMotionOn[TimeKeepW-1:0]);

  logic                 target_on_q, target_on_d;
  logic [DUTY_BITS-1:0] cur_q, cur_d;
  logic [TIME_BITS-1:0] auto_off_q, auto_off_d;
  logic [TIME_BITS-1:0] block_q, block_d;

  logic [TIME_BITS-1:0] switch_on_t, switch_block_t, motion_on_t;
  logic [TIME_BITS-1:0] auto_off_dec, block_dec;
  logic [StepW-1:0]     step;
  logic [SumW-1:0]      cur_x, step_x, sum_x;
  logic                 moved;
  logic [DUTY_BITS-1:0] duty_full;

  // Time registers are kept at the counter width.
  assign switch_on_t    = TIME_BITS'(cfg_i.switch_on_time[TimeKeepW-1:0]);
  assign switch_block_t = TIME_BITS'(cfg_i.switch_block_time[TimeKeepW-1:0]);
  assign motion_on_t    = TIME_BITS'(cfg_i.motion_on_time[TimeKeepW-1:0]);

  // A zero step behaves as a step of one.
  assign step   = (cfg_i.fade_step == '0) ? StepW'(1) : cfg_i.fade_step;
  assign step_x = SumW'(step);

  assign auto_off_dec = (auto_off_q != '0) ? auto_off_q - TIME_BITS'(1) : auto_off_q;
  assign block_dec    = (block_q != '0) ? block_q - TIME_BITS'(1) : block_q;
  assign cur_x        = SumW'(cur_q);
  assign sum_x        = cur_x + step_x;

  // Next-state logic for one item.
  always_comb begin
    target_on_d = target_on_q;
    cur_d       = cur_q;
    auto_off_d  = auto_off_q;
    block_d     = block_q;
    moved       = 1'b0;
    case (op_e'(op_i))
      OP_SWITCH: begin
        target_on_d = !target_on_q;
        auto_off_d  = switch_on_t;
        if (target_on_q) begin
          block_d = switch_block_t;
        end
      end
      OP_MOTION: begin
        if (!motion_level_i) begin
          auto_off_d = motion_on_t;
        end else if (block_q == '0) begin
          target_on_d = 1'b1;
          auto_off_d  = motion_on_t;
        end
      end
      OP_TICK: begin
        auto_off_d = auto_off_dec;
        block_d    = block_dec;
        if (target_on_q && auto_off_dec == '0) begin
          if (motion_level_i) begin
            auto_off_d = motion_on_t;
          end else begin
            target_on_d = 1'b0;
          end
        end
        // Fade one step toward the new target.
        if (target_on_d && cur_q != LvlMax) begin
          cur_d = (sum_x > LvlMaxX) ? LvlMax : DUTY_BITS'(sum_x);
          moved = 1'b1;
        end else if (!target_on_d && cur_q != '0) begin
          cur_d = (cur_x > step_x) ? DUTY_BITS'(cur_x - step_x) : '0;
          moved = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_on_q <= 1'b1;
      cur_q       <= LvlMax;
      auto_off_q  <= RstAutoOff;
      block_q     <= '0;
    end else if (en_i) begin
      target_on_q <= target_on_d;
      cur_q       <= cur_d;
      auto_off_q  <= auto_off_d;
      block_q     <= block_d;
    end
  end

  // Output encoding from the level after this item.
  logic [SumW-1:0] nsum_x;
  assign nsum_x    = SumW'(cur_d) + step_x;
  assign duty_full = cfg_i.invert_output ? (LvlMax - cur_d) : cur_d;

  always_comb begin
    flags_o.duty_written    = moved;
    flags_o.light_target_on = target_on_d;
    flags_o.output_held     = 1'b1;
    duty_o                  = '0;
    if (nsum_x > LvlMaxX) begin
      flags_o.held_level = !cfg_i.invert_output;
    end else if (cur_d != '0) begin
      flags_o.output_held = 1'b0;
      flags_o.held_level  = 1'b0;
      duty_o              = DUTY_BITS'(duty_full[DutyOutW-1:0]);
    end else begin
      flags_o.held_level = cfg_i.invert_output;
    end
  end

endmodule

/* design/occupancy_light_fader.sv */
// Top level of the occupancy light fader: input stage, core and result register.
//
//  channel   direction  handshake                 payload
//  in        in         in_valid_i / in_stall_o   in_op_i, in_motion_level_i
//  out       out        out_valid_o / out_stall_i duty_value_o, output_held_o,
//                                                 held_level_o, duty_written_o,
//                                                 light_target_on_o
//  cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per cycle while the result register is free: an item waits in the
// input register, then the core updates the light state and the result register
// takes its result. Each result passes through the input register and then the
// result register before it can transfer.
// Reset puts the light at full on with the auto-off countdown at its default.
// A stalled result holds; the input stage keeps taking items until both the
// input register and the result register are full.
module occupancy_light_fader #(
  parameter int unsigned DUTY_BITS = 13,
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [olf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [olf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [olf_pkg::OpW-1:0]      in_op_i,
  input  logic                         in_motion_level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DUTY_BITS-1:0]         duty_value_o,
  output logic                         output_held_o,
  output logic                         held_level_o,
  output logic                         duty_written_o,
  output logic                         light_target_on_o
);
  import olf_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid_q;
  logic [OpW-1:0]       s1_op_q;
  logic                 s1_motion_q;
  logic                 out_valid_q;
  logic                 advance;
  logic                 core_en;
  logic                 in_xfer;
  logic [DUTY_BITS-1:0] core_duty;
  res_flags_t           core_flags;
  logic [DUTY_BITS-1:0] duty_q;
  res_flags_t           flags_q;

  olf_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // Pipeline control: the result register frees when empty or taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign core_en    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= in_op_i;
      s1_motion_q <= in_motion_level_i;
    end
  end

  olf_core #(
    .DUTY_BITS (DUTY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .en_i           (core_en),
    .op_i           (s1_op_q),
    .motion_level_i (s1_motion_q),
    .cfg_i          (cfg),
    .duty_o         (core_duty),
    .flags_o        (core_flags)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_en) begin
      duty_q  <= core_duty;
      flags_q <= core_flags;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign duty_value_o      = duty_q;
  assign output_held_o     = flags_q.output_held;
  assign held_level_o      = flags_q.held_level;
  assign duty_written_o    = flags_q.duty_written;
  assign light_target_on_o = flags_q.light_target_on;

  // The input side only backs up when both stages are full and the output stalls.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // An item processed by the core shows up as a valid result next cycle.
  a_core_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_en |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // A held output carries a zero compare value.
  a_held_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && output_held_o) |-> (duty_value_o == '0))
    else $error("held output with nonzero duty value");

endmodule

/* tb/occupancy_light_fader_tb.sv */
// Self-checking testbench for the occupancy light fader with a built-in behavioral predictor.
`timescale 1ns / 100ps

module occupancy_light_fader_tb;
  import olf_pkg::*;

  localparam int unsigned DutyW = 13;
  localparam int unsigned TimeW = 24;
  localparam logic [DutyW-1:0] LevelMax = {DutyW{1'b1}};

  // One light event waiting to be sent, and one predicted output word.
  typedef struct {
    op_e  op;
    logic motion;
    bit   drain_first;
  } light_event_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             held;
    logic             held_level;
    logic             written;
    logic             target_on;
  } light_result_t;

  // How the two sides pause during a stretch of traffic.
  typedef enum int {
    PACE_FULL,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_e;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_SWITCH_ON;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  op_e                 in_op = OP_TICK;
  logic                in_motion = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DutyW-1:0]    duty_value;
  logic                output_held;
  logic                held_level;
  logic                duty_written;
  logic                light_target_on;

  light_event_t  queued_events[$];
  light_result_t predicted_lamp_q[$];
  light_event_t  on_wire;
  pace_e         pace = PACE_FULL;
  logic          sensor_level = 1'b0;
  int unsigned   fail_count = 0;

  // Predictor copy of the configuration and the light state.
  logic [TimeW-1:0] switch_on_ticks;
  logic [TimeW-1:0] switch_block_ticks;
  logic [TimeW-1:0] motion_on_ticks;
  logic [DutyW-1:0] fade_step;
  logic             invert;
  logic [DutyW-1:0] lamp_target;
  logic [DutyW-1:0] lamp_level;
  logic [TimeW-1:0] off_left;
  logic [TimeW-1:0] block_left;

  occupancy_light_fader #(
    .DUTY_BITS(DutyW),
    .TIME_BITS(TimeW)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_op_i          (in_op),
    .in_motion_level_i(in_motion),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .duty_value_o     (duty_value),
    .output_held_o    (output_held),
    .held_level_o     (held_level),
    .duty_written_o   (duty_written),
    .light_target_on_o(light_target_on)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Put the predictor into its power-on state.
  task automatic reset_light_model();
    switch_on_ticks    = RstSwitchOn;
    switch_block_ticks = RstSwitchBlock;
    motion_on_ticks    = RstMotionOn;
    fade_step          = RstFadeStep;
    invert             = 1'b0;
    lamp_target        = LevelMax;
    lamp_level         = LevelMax;
    off_left           = RstMotionOn;
    block_left         = '0;
  endtask

  // Apply one event to the light state and return the output word it yields.
  function automatic light_result_t apply_light_event(op_e op, logic motion);
    light_result_t r;
    logic [DutyW-1:0] step;
    logic [DutyW:0]   sum;
    logic             moved;
    step  = (fade_step == '0) ? DutyW'(1) : fade_step;
    moved = 1'b0;
    case (op)
      OP_SWITCH: begin
        lamp_target = (lamp_target != '0) ? '0 : LevelMax;
        off_left    = switch_on_ticks;
        if (lamp_target == '0) block_left = switch_block_ticks;
      end
      OP_MOTION: begin
        // A rise inside the block window is dropped; a fall only restarts the countdown.
        if (motion) begin
          if (block_left == '0) begin
            lamp_target = LevelMax;
            off_left    = motion_on_ticks;
          end
        end else begin
          off_left = motion_on_ticks;
        end
      end
      OP_TICK: begin
        if (off_left != '0) off_left = off_left - TimeW'(1);
        if (block_left != '0) block_left = block_left - TimeW'(1);
        if (lamp_target != '0 && off_left == '0) begin
          if (motion) off_left = motion_on_ticks;
          else lamp_target = '0;
        end
        if (lamp_level < lamp_target) begin
          sum        = {1'b0, lamp_level} + {1'b0, step};
          lamp_level = (sum > {1'b0, LevelMax}) ? LevelMax : sum[DutyW-1:0];
          moved      = 1'b1;
        end
        if (lamp_level > lamp_target) begin
          lamp_level = (lamp_level > step) ? lamp_level - step : '0;
          moved      = 1'b1;
        end
      end
      default: ;
    endcase

    // Near-full and zero levels hold the pin; anything else is modulated.
    sum         = {1'b0, lamp_level} + {1'b0, step};
    r           = '0;
    r.written   = moved;
    r.target_on = (lamp_target == LevelMax);
    if (sum > {1'b0, LevelMax}) begin
      r.held       = 1'b1;
      r.held_level = ~invert;
    end else if (lamp_level != '0) begin
      r.duty = invert ? LevelMax - lamp_level : lamp_level;
    end else begin
      r.held       = 1'b1;
      r.held_level = invert;
    end
    return r;
  endfunction

  function automatic bit sender_rests();
    case (pace)
      PACE_SENDER: return $urandom_range(99) < 48;
      PACE_BOTH:   return $urandom_range(99) < 14;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (pace)
      PACE_RECEIVER: return $urandom_range(99) < 48;
      PACE_BOTH:     return $urandom_range(99) < 14;
      default:       return 1'b0;
    endcase
  endfunction

  // Input driver: predict on each transfer, then present the next queued event.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) predicted_lamp_q.push_back(apply_light_event(on_wire.op,
                                                                             on_wire.motion));
      if (!in_valid || !in_stall) begin
        if (queued_events.size() > 0 && !sender_rests() &&
            !(queued_events[0].drain_first && predicted_lamp_q.size() > 0)) begin
          on_wire   = queued_events.pop_front();
          in_valid  <= 1'b1;
          in_op     <= on_wire.op;
          in_motion <= on_wire.motion;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Output monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    light_result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_lamp_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = predicted_lamp_q.pop_front();
          check_field("duty_value", want.duty, duty_value);
          check_field("output_held", want.held, output_held);
          check_field("held_level", want.held_level, held_level);
          check_field("duty_written", want.written, duty_written);
          check_field("light_target_on", want.target_on, light_target_on);
        end
      end
      out_stall <= receiver_rests();
    end
  end

  task automatic push_event(op_e op, logic motion, bit drain_first = 1'b0);
    light_event_t ev;
    ev.op          = op;
    ev.motion      = motion;
    ev.drain_first = drain_first;
    queued_events.push_back(ev);
  endtask

  // Mostly ticks that follow a consistent sensor level, with switch presses,
  // sensor edges, the unused code and some level noise mixed in.
  task automatic push_activity(int unsigned count, int unsigned edge_pct);
    int unsigned roll;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        push_event(OP_SWITCH, sensor_level, k == count / 2);
      end else if (roll < 12) begin
        push_event(OP_NONE, 1'($urandom), k == count / 2);
      end else if (roll < 12 + edge_pct) begin
        sensor_level = ~sensor_level;
        push_event(OP_MOTION, sensor_level, k == count / 2);
      end else begin
        push_event(OP_TICK, ($urandom_range(99) < 5) ? ~sensor_level : sensor_level,
                   k == count / 2);
      end
    end
  endtask

  // Wait until every event is sent and every result has come back, then a little more.
  task automatic settle();
    while (queued_events.size() > 0 || in_valid || predicted_lamp_q.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SWITCH_ON:    switch_on_ticks = data[TimeW-1:0];
      CFG_SWITCH_BLOCK: switch_block_ticks = data[TimeW-1:0];
      CFG_MOTION_ON:    motion_on_ticks = data[TimeW-1:0];
      CFG_FADE_STEP:    fade_step = data[StepW-1:0];
      CFG_INVERT:       invert = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CfgDataW-1:0] on_ticks, logic [CfgDataW-1:0] blk_ticks,
                           logic [CfgDataW-1:0] mot_ticks, logic [CfgDataW-1:0] step_data,
                           logic inv);
    write_reg(CFG_SWITCH_ON, on_ticks);
    write_reg(CFG_SWITCH_BLOCK, blk_ticks);
    write_reg(CFG_MOTION_ON, mot_ticks);
    write_reg(CFG_FADE_STEP, step_data);
    write_reg(CFG_INVERT, {{(CfgDataW-1){1'b0}}, inv});
  endtask

  // Stimulus sequence and end of test.
  initial begin
    int unsigned             edge_pct;
    logic [CfgDataW-1:0]     step_data;
    reset_light_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Power-on settings: unused code, falling edge, switch off, blocked rise, fading down.
    push_event(OP_NONE, 1'b0);
    push_event(OP_NONE, 1'b1);
    push_event(OP_TICK, 1'b0);
    push_event(OP_MOTION, 1'b0);
    push_event(OP_SWITCH, 1'b0);
    push_event(OP_MOTION, 1'b1);
    push_event(OP_TICK, 1'b1);
    push_event(OP_TICK, 1'b0);
    push_event(OP_SWITCH, 1'b1);
    push_event(OP_TICK, 1'b0);
    settle();

    // Short timers, zero step and zero motion time, inverted output.
    configure(24'd2, 24'd2, 24'd0, 24'd0, 1'b1);
    push_event(OP_SWITCH, 1'b0);
    push_event(OP_MOTION, 1'b1);
    push_event(OP_TICK, 1'b1);
    push_event(OP_TICK, 1'b1);
    push_event(OP_MOTION, 1'b1);
    push_event(OP_TICK, 1'b1);
    push_event(OP_TICK, 1'b1);
    push_event(OP_TICK, 1'b0);
    push_event(OP_TICK, 1'b0);
    push_event(OP_MOTION, 1'b0);
    push_event(OP_SWITCH, 1'b1);
    push_event(OP_NONE, 1'b1);
    push_event(OP_TICK, 1'b1);
    settle();

    // Random traffic over several settings, each split across all pacing styles.
    for (int unsigned p = 0; p < 5; p++) begin
      case (p)
        0: begin
          configure(24'd12, 24'd6, 24'd9, 24'd700, 1'b0);
          edge_pct = 8;
        end
        1: begin
          configure('1, '0, '1, 24'd8191, 1'b1);
          edge_pct = 20;
        end
        2: begin
          configure('0, '1, '0, 24'd1, 1'b0);
          edge_pct = 10;
        end
        default: begin
          step_data = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(1, 8191))
                                                   : CfgDataW'($urandom_range(1, 300));
          step_data = step_data | (CfgDataW'($urandom_range(0, 2047)) << StepW);
          configure(CfgDataW'($urandom_range(0, 30)), CfgDataW'($urandom_range(0, 20)),
                    CfgDataW'($urandom_range(0, 25)), step_data, 1'($urandom));
          edge_pct = $urandom_range(6, 15);
        end
      endcase
      for (int unsigned chunk = 0; chunk < 4; chunk++) begin
        pace = pace_e'((chunk + p) % 4);
        push_activity(94, edge_pct);
        while (queued_events.size() > 0) @(posedge clk_i);
      end
      settle();
    end

    pace = PACE_FULL;
    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
